### design/pstk_pkg.sv
// ----------------------------------------------------------------------------
// pstk_pkg
// Shared operation and status codes and the control type for the priority stack.
// ----------------------------------------------------------------------------
package pstk_pkg;

  localparam logic       MODE_PUSH = 1'b0;
  localparam logic       MODE_POP  = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL_DROP = 2'd1;
  localparam logic [1:0] STATUS_POP_EMPTY = 2'd2;

  // per-transaction control broadcast to every cell
  typedef struct packed {
    logic push;   // accepted push that fits
    logic pop;    // accepted pop on a non-empty store
  } pstk_ctrl_t;

endpackage

### design/pstk_cell.sv
// ----------------------------------------------------------------------------
// pstk_cell
// One slot of the sorted chain: keeps, shifts in from a neighbor or inserts.
// ----------------------------------------------------------------------------
module pstk_cell import pstk_pkg::*; #(
  parameter int ELEM_BITS = 32,
  parameter int PRIO_BITS = 16
) (
  input  logic                 clk,
  input  pstk_ctrl_t           ctrl,
  input  logic                 occupied,
  input  logic [ELEM_BITS-1:0] new_elem,
  input  logic [PRIO_BITS-1:0] new_prio,
  input  logic                 prev_le,
  input  logic [ELEM_BITS-1:0] prev_elem,
  input  logic [PRIO_BITS-1:0] prev_prio,
  input  logic [ELEM_BITS-1:0] next_elem,
  input  logic [PRIO_BITS-1:0] next_prio,
  output logic                 le,
  output logic [ELEM_BITS-1:0] elem,
  output logic [PRIO_BITS-1:0] prio
);

  logic [ELEM_BITS-1:0] elem_next;
  logic [PRIO_BITS-1:0] prio_next;

  // new entry goes ahead of this slot (free slots count as "ahead")
  assign le = !occupied || (prio <= new_prio);

  always_comb begin
    elem_next = elem;
    prio_next = prio;
    if (ctrl.push) begin
      if (prev_le) begin
        elem_next = prev_elem;
        prio_next = prev_prio;
      end else if (le) begin
        elem_next = new_elem;
        prio_next = new_prio;
      end
    end else if (ctrl.pop) begin
      elem_next = next_elem;
      prio_next = next_prio;
    end
  end

  always_ff @(posedge clk) begin
    elem <= elem_next;
    prio <= prio_next;
  end

endmodule

### design/pstk_outbuf.sv
// ----------------------------------------------------------------------------
// pstk_outbuf
// Result register with a skid stage so a stalled receiver never drops data.
// ----------------------------------------------------------------------------
module pstk_outbuf #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  logic [W-1:0] data,
  output logic         busy,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [W-1:0] out_data
);

  logic         skid_valid;
  logic [W-1:0] skid_data;
  logic         out_fire;

  assign out_fire = out_valid && !out_stall;
  assign busy     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (load) begin
      if (!out_valid || out_fire) begin
        out_data  <= data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= data;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### design/priority_stack_top.sv
// ----------------------------------------------------------------------------
// priority_stack_top
// Bounded priority stack built as a chain of sorted cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one transaction per item:
//   mode=push stores element with prio, mode=pop removes the head entry.
//   Entries stay sorted by descending prio; a push lands ahead of every entry
//   with lower or equal prio, so equal priorities leave newest first.
//   Output channel (out_valid/out_stall) returns one transaction per item with
//   the head entry, is_empty, count and status after that item.
//   Result: each result is registered, or held in the skid stage while the output stalls.
//   Throughput: one item per cycle while in_stall is low; every cell compares
//   against the incoming prio in parallel and shifts in the same cycle.
//   Stall: a result register plus a skid stage hold up to two results; while
//   the skid stage is occupied in_stall is high, and held results keep their
//   values until taken.
//   Reset: count returns to zero; cell contents are not cleared (slots at or
//   beyond count are never shown). No clearing pass is needed.
// ----------------------------------------------------------------------------
module priority_stack_top import pstk_pkg::*; #(
  parameter int CAPACITY  = 16,
  parameter int ELEM_BITS = 32,
  parameter int PRIO_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               mode,
  input  logic [ELEM_BITS-1:0]               element,
  input  logic [PRIO_BITS-1:0]               prio,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ELEM_BITS-1:0]               head_element,
  output logic [PRIO_BITS-1:0]               head_prio,
  output logic                               is_empty,
  output logic [$clog2(CAPACITY+1)-1:0]      count,
  output logic [1:0]                         status
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = ELEM_BITS + PRIO_BITS + 1 + CW + 2;

  logic                 accept;
  logic [CW-1:0]        used;
  logic [CW-1:0]        used_next;
  logic                 full;
  logic                 empty;
  pstk_ctrl_t           ctrl;
  logic [1:0]           status_next;
  logic                 busy;

  logic [ELEM_BITS-1:0] cell_elem [CAPACITY];
  logic [PRIO_BITS-1:0] cell_prio [CAPACITY];
  logic                 cell_le   [CAPACITY];

  // head after this transaction, taken from cell 0's next-state view
  logic [ELEM_BITS-1:0] head_elem_next;
  logic [PRIO_BITS-1:0] head_prio_next;
  logic                 empty_next;
  logic [RW-1:0]        result;
  logic [RW-1:0]        out_data;

  assign accept = in_valid && !in_stall;
  assign in_stall = busy;
  assign full   = (used == CW'(CAPACITY));
  assign empty  = (used == '0);

  assign ctrl.push = accept && (mode == MODE_PUSH) && !full;
  assign ctrl.pop  = accept && (mode == MODE_POP) && !empty;

  always_comb begin
    used_next = used;
    if (ctrl.push)     used_next = used + CW'(1);
    else if (ctrl.pop) used_next = used - CW'(1);
  end

  always_comb begin
    status_next = STATUS_OK;
    if (mode == MODE_PUSH && full)      status_next = STATUS_FULL_DROP;
    else if (mode == MODE_POP && empty) status_next = STATUS_POP_EMPTY;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used_next;
    end
  end

  // ---------------------------------------------------------------------------
  // cell chain: cell 0 is the head
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 prev_le;
    logic [ELEM_BITS-1:0] prev_elem;
    logic [PRIO_BITS-1:0] prev_prio;
    logic [ELEM_BITS-1:0] next_elem;
    logic [PRIO_BITS-1:0] next_prio;

    if (i == 0) begin : g_first
      assign prev_le   = 1'b0;
      assign prev_elem = cell_elem[i];
      assign prev_prio = cell_prio[i];
    end else begin : g_mid
      assign prev_le   = cell_le[i-1];
      assign prev_elem = cell_elem[i-1];
      assign prev_prio = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_elem = cell_elem[i];
      assign next_prio = cell_prio[i];
    end else begin : g_inner
      assign next_elem = cell_elem[i+1];
      assign next_prio = cell_prio[i+1];
    end

    pstk_cell #(
      .ELEM_BITS (ELEM_BITS),
      .PRIO_BITS (PRIO_BITS)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (CW'(i) < used),
      .new_elem  (element),
      .new_prio  (prio),
      .prev_le   (prev_le),
      .prev_elem (prev_elem),
      .prev_prio (prev_prio),
      .next_elem (next_elem),
      .next_prio (next_prio),
      .le        (cell_le[i]),
      .elem      (cell_elem[i]),
      .prio      (cell_prio[i])
    );
  end

  // head after the transaction: new item if it lands at slot 0, cell 1 on pop
  always_comb begin
    head_elem_next = cell_elem[0];
    head_prio_next = cell_prio[0];
    if (ctrl.push && cell_le[0]) begin
      head_elem_next = element;
      head_prio_next = prio;
    end else if (ctrl.pop) begin
      head_elem_next = cell_elem[1];
      head_prio_next = cell_prio[1];
    end
  end

  assign empty_next = (used_next == '0);

  assign result = {
    empty_next ? '0 : head_elem_next,
    empty_next ? '0 : head_prio_next,
    empty_next,
    used_next,
    status_next
  };

  pstk_outbuf #(
    .W (RW)
  ) u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .data      (result),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign {head_element, head_prio, is_empty, count, status} = out_data;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.push |=> used == $past(used) + CW'(1))
    else $error("accepted push did not grow the store");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |=> used == $past(used) - CW'(1))
    else $error("accepted pop did not shrink the store");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (used >= CW'(2)) |-> (cell_prio[0] >= cell_prio[1]))
    else $error("head entry out of priority order");

  a_drop_only_full: assert property (@(posedge clk) disable iff (rst)
    (accept && status_next == STATUS_FULL_DROP) |-> (full && !ctrl.push))
    else $error("push dropped on a store that was not full");

endmodule

### tb/sv/priority_stack_top_chk.sv
// ----------------------------------------------------------------------------
// priority_stack_top_chk
// Scoreboard for the priority stack: watches both channels, keeps its own
// sorted copy of the store, and compares every returned head report.
// ----------------------------------------------------------------------------
module priority_stack_top_chk import pstk_pkg::*; #(
  parameter int CAPACITY  = 16,
  parameter int ELEM_BITS = 32,
  parameter int PRIO_BITS = 16,
  parameter int CNT_BITS  = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 mode,
  input  logic [ELEM_BITS-1:0] element,
  input  logic [PRIO_BITS-1:0] prio,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [ELEM_BITS-1:0] head_element,
  input  logic [PRIO_BITS-1:0] head_prio,
  input  logic                 is_empty,
  input  logic [CNT_BITS-1:0]  count,
  input  logic [1:0]           status,
  output int                   errors,
  output int                   pending
);

  typedef struct packed {
    logic [ELEM_BITS-1:0] elem;
    logic [PRIO_BITS-1:0] pri;
  } entry_t;

  typedef struct packed {
    logic [ELEM_BITS-1:0] elem;
    logic [PRIO_BITS-1:0] pri;
    logic                 empty;
    logic [CNT_BITS-1:0]  cnt;
    logic [1:0]           st;
  } head_report_t;

  entry_t       sorted_store [CAPACITY];
  int           store_depth;
  head_report_t head_reports_due [$];
  int           miscount;

  // Apply one push/pop to the shadow store and return the head report.
  function automatic head_report_t next_head_report(logic op,
                                                     logic [ELEM_BITS-1:0] e,
                                                     logic [PRIO_BITS-1:0] p);
    head_report_t r;
    int           pos;
    int           k;
    r = '0;
    r.st = STATUS_OK;
    if (op == MODE_PUSH) begin
      if (store_depth >= CAPACITY) begin
        r.st = STATUS_FULL_DROP;
      end else begin
        // new entry goes ahead of anything with lower or equal priority
        pos = 0;
        while (pos < store_depth && sorted_store[pos].pri > p) pos++;
        for (k = store_depth; k > pos; k--) sorted_store[k] = sorted_store[k-1];
        sorted_store[pos].elem = e;
        sorted_store[pos].pri  = p;
        store_depth++;
      end
    end else begin
      if (store_depth == 0) begin
        r.st = STATUS_POP_EMPTY;
      end else begin
        for (k = 0; k + 1 < store_depth; k++) sorted_store[k] = sorted_store[k+1];
        store_depth--;
      end
    end
    if (store_depth == 0) begin
      r.empty = 1'b1;
    end else begin
      r.elem = sorted_store[0].elem;
      r.pri  = sorted_store[0].pri;
    end
    r.cnt = CNT_BITS'(store_depth);
    return r;
  endfunction

  always @(posedge clk) begin
    head_report_t want;
    logic         bad;
    if (rst) begin
      store_depth = 0;
      miscount    = 0;
      head_reports_due.delete();
    end else begin
      // result first: it belongs to an earlier transaction than any input
      // accepted at this same edge
      if (out_valid && !out_stall) begin
        if (head_reports_due.size() == 0) begin
          miscount++;
          if (miscount <= 10)
            $display("[%0t] unexpected result: elem=%h prio=%h empty=%b cnt=%0d st=%0d",
                     $realtime, head_element, head_prio, is_empty, count, status);
        end else begin
          want = head_reports_due.pop_front();
          bad  = (head_element !== want.elem) || (head_prio !== want.pri) ||
                 (is_empty !== want.empty) || (count !== want.cnt) ||
                 (status !== want.st);
          if (bad) begin
            miscount++;
            if (miscount <= 10) begin
              $write("[%0t] mismatch: exp elem=%h prio=%h empty=%b cnt=%0d st=%0d",
                     $realtime, want.elem, want.pri, want.empty, want.cnt, want.st);
              $display(" | got elem=%h prio=%h empty=%b cnt=%0d st=%0d",
                       head_element, head_prio, is_empty, count, status);
            end
          end
        end
      end
      if (in_valid && !in_stall)
        head_reports_due.push_back(next_head_report(mode, element, prio));
    end
    errors  <= miscount;
    pending <= head_reports_due.size();
  end

endmodule

### tb/sv/priority_stack_top_tb.sv
// ----------------------------------------------------------------------------
// priority_stack_top_tb
// Drives push/pop transactions into the priority stack with random gaps and
// output stalls; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module priority_stack_top_tb import pstk_pkg::*;;

  localparam int CAPACITY  = 16;
  localparam int ELEM_BITS = 32;
  localparam int PRIO_BITS = 16;
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic                 mode      = MODE_PUSH;
  logic [ELEM_BITS-1:0] element   = '0;
  logic [PRIO_BITS-1:0] prio      = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ELEM_BITS-1:0] head_element;
  logic [PRIO_BITS-1:0] head_prio;
  logic                 is_empty;
  logic [CNT_BITS-1:0]  count;
  logic [1:0]           status;

  int   errors;
  int   pending;
  // when set, neither side idles: gives a long back-to-back stretch
  logic steady = 1'b0;

  priority_stack_top #(
    .CAPACITY (CAPACITY),
    .ELEM_BITS(ELEM_BITS),
    .PRIO_BITS(PRIO_BITS)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .element     (element),
    .prio        (prio),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .head_element(head_element),
    .head_prio   (head_prio),
    .is_empty    (is_empty),
    .count       (count),
    .status      (status)
  );

  priority_stack_top_chk #(
    .CAPACITY (CAPACITY),
    .ELEM_BITS(ELEM_BITS),
    .PRIO_BITS(PRIO_BITS)
  ) chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .element     (element),
    .prio        (prio),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .head_element(head_element),
    .head_prio   (head_prio),
    .is_empty    (is_empty),
    .count       (count),
    .status      (status),
    .errors      (errors),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit; a healthy run needs well under a tenth of this.
  initial begin
    #2_000_000;
    $display("priority_stack_top regression: fail");
    $finish;
  end

  // Receiver: stalls about a quarter of the cycles, never while steady.
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 26);
  end

  // Offer one transaction; returns at the edge where it was taken.
  // An idle gap is inserted at random before the offer (never while steady); the
  // payload is scrambled while valid is low so it carries no meaning then.
  task automatic issue_op(input logic op, input logic [ELEM_BITS-1:0] e,
                          input logic [PRIO_BITS-1:0] p);
    int gap;
    if (!steady && $urandom_range(99) < 26) begin
      gap = $urandom_range(1, 2);
      in_valid <= 1'b0;
      mode     <= 1'($urandom_range(1));
      element  <= ELEM_BITS'($urandom);
      prio     <= PRIO_BITS'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= op;
    element  <= e;
    prio     <= p;
    @(posedge clk);
    // payload held steady until the block lets it in
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    int                   n;
    int                   k;
    int                   push_pct;
    int                   sel;
    logic [ELEM_BITS-1:0] e;
    logic [PRIO_BITS-1:0] p;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    // pop on an empty store: flagged, nothing changes
    issue_op(MODE_POP, 32'hDEAD_BEEF, 16'h1234);
    // field extremes
    issue_op(MODE_PUSH, '0, '0);
    issue_op(MODE_PUSH, '1, '1);
    // tie at the top priority: newest must become head
    issue_op(MODE_PUSH, 32'hA5A5_5A5A, '1);
    // tie at the lowest priority: lands ahead of the older zero-prio entry
    issue_op(MODE_PUSH, 32'h5A5A_A5A5, '0);
    // pop removes the newest of the top-priority tie
    issue_op(MODE_POP, '1, '1);
    // fill to capacity with a mix of small priorities to force ties
    for (k = 0; k < CAPACITY - 3; k++)
      issue_op(MODE_PUSH, ELEM_BITS'(32'h0100_0000 + k), PRIO_BITS'(k % 4));
    // push into a full store: dropped and flagged
    issue_op(MODE_PUSH, 32'hFFFF_0000, 16'h8000);
    issue_op(MODE_POP, '0, '0);

    // ---- random part ----
    // Runs of 100 transactions share a push bias so the store wanders between
    // empty and full. Priorities are mostly a narrow band to make ties common.
    push_pct = 50;
    for (n = 0; n < 1300; n++) begin
      if (n % 100 == 0) begin
        sel = $urandom_range(2);
        push_pct = (sel == 0) ? 15 : (sel == 1) ? 50 : 85;
      end
      steady <= (n >= 500 && n < 800);
      sel = $urandom_range(9);
      if (sel < 5)       p = PRIO_BITS'($urandom_range(7));
      else if (sel == 5) p = '0;
      else if (sel == 6) p = '1;
      else               p = PRIO_BITS'($urandom);
      sel = $urandom_range(19);
      if (sel == 0)      e = '0;
      else if (sel == 1) e = '1;
      else               e = ELEM_BITS'($urandom);
      issue_op(($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_POP, e, p);
    end

    in_valid <= 1'b0;
    steady   <= 1'b0;
    // one edge so the checker has logged the last accepted transaction
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // further edges catch any stray result
    repeat (5) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("priority_stack_top regression: pass");
    end else begin
      $display("priority_stack_top regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
design/pstk_pkg.sv
design/pstk_cell.sv
design/pstk_outbuf.sv
design/priority_stack_top.sv
tb/sv/priority_stack_top_chk.sv
tb/sv/priority_stack_top_tb.sv
